// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off while
// the synchronous active-low reset i_rst_n is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define FCCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define FCCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fcct_pkg.sv =====
// ----------------------------------------------------------------------------
// fcct_pkg
// Operation codes, register map offsets and fixed constants of the
// five-channel compare timer.
// ----------------------------------------------------------------------------
package fcct_pkg;

    // Number of timer slots seen on the result ports.
    localparam int SLOTS = 5;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_READ_BYTE  = 2'd1,
        OP_WRITE_BYTE = 2'd2,
        OP_WRITE_HALF = 2'd3
    } t_op;

    // Shared register addresses.
    localparam logic [5:0] ADDR_START = 6'h00;
    localparam logic [5:0] ADDR_SYNC  = 6'h01;
    localparam logic [5:0] ADDR_MODE  = 6'h02;
    localparam logic [5:0] ADDR_FIRST_TIMER = 6'h04;

    // Timer register windows.
    localparam logic [5:0] BASE_T0      = 6'h04;
    localparam logic [5:0] TIMER_STRIDE = 6'h0A;
    localparam logic [5:0] BASE_T3      = 6'h22;
    localparam logic [5:0] END_T3       = 6'h30;
    localparam logic [5:0] BASE_T4      = 6'h32;

    // Offsets inside one timer window.
    localparam logic [3:0] REG_CTRL   = 4'd0;
    localparam logic [3:0] REG_IER    = 4'd2;
    localparam logic [3:0] REG_FLAGS  = 4'd3;
    localparam logic [3:0] REG_CNT_HI = 4'd4;
    localparam logic [3:0] REG_CNT_LO = 4'd5;
    localparam logic [3:0] REG_CMP_A  = 4'd6;
    localparam logic [3:0] REG_CMP_B  = 4'd8;

    // Constant bits that reads return alongside the stored value.
    localparam logic [7:0] SHARED_READ_PAD = 8'h60;
    localparam logic [7:0] FLAG_READ_PAD   = 8'h78;

    // Interrupt cause codes.
    localparam logic [1:0] CAUSE_CMP_A   = 2'd0;
    localparam logic [1:0] CAUSE_FLAG1   = 2'd1;
    localparam logic [1:0] CAUSE_FLAG2   = 2'd2;
    localparam logic [1:0] CAUSE_INVALID = 2'd3;

endpackage

// ===== hdl/five_channel_compare_timer.sv =====
// ----------------------------------------------------------------------------
// five_channel_compare_timer
// Up to five 16-bit up-counting compare timers behind a byte-addressed
// register map, driven by tick and bus items on one channel.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is a tick, a byte read, a byte write or a halfword write
// (i_operation, i_addr, i_wdata). It is taken at a rising edge with
// i_in_valid high and o_in_stall low. Every item produces exactly one
// result item: the byte read back (zero for ticks and writes) and the
// interrupt state of all timers as it stands after the item.
// An accepted item is held in the input register, processed by single-level
// logic against the timer state and written to the result register when that
// register can take it, and its result is offered from there. The block takes
// one item per clock for as long as results are taken, so the throughput is
// one item per cycle. When the receiver raises i_out_stall the result
// register holds its item, the input register fills, and o_in_stall rises
// only once both are full. A synchronous active-low reset clears all timer
// state and empties both registers; the block accepts an item in the first
// cycle after reset.
// ----------------------------------------------------------------------------
module five_channel_compare_timer #(
    parameter int NUM_TIMERS  = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [5:0]                  i_addr,
    input  logic [15:0]                 i_wdata,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_read_data,
    output logic [fcct_pkg::SLOTS-1:0]  o_irq_pending,
    output logic [1:0]                  o_irq_cause_t0,
    output logic [1:0]                  o_irq_cause_t1,
    output logic [1:0]                  o_irq_cause_t2,
    output logic [1:0]                  o_irq_cause_t3,
    output logic [1:0]                  o_irq_cause_t4
);
    import fcct_pkg::*;

    // ------------------------------------------------------------------
    // Handshake and pipeline registers
    // ------------------------------------------------------------------
    logic        r_s1_valid;
    logic [1:0]  r_op;
    logic [5:0]  r_addr;
    logic [15:0] r_wdata;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [SLOTS-1:0] r_pending;
    logic [1:0]  r_cause [SLOTS];

    logic advance;
    logic in_accept;
    logic s1_process;

    // The result register can take a new item when it is empty or its item
    // leaves in this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign s1_process = r_s1_valid && advance;

    // ------------------------------------------------------------------
    // Timer state
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] r_count  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_cmp_a  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_cmp_b  [NUM_TIMERS];
    logic [2:0]             r_clk_sel  [NUM_TIMERS];
    logic [1:0]             r_edge_sel [NUM_TIMERS];
    logic [1:0]             r_clr_sel  [NUM_TIMERS];
    logic [2:0]             r_ier    [NUM_TIMERS];
    logic [2:0]             r_flags  [NUM_TIMERS];
    logic [2:0]             r_phase  [NUM_TIMERS];
    logic [4:0]             r_start;
    logic [4:0]             r_sync;
    logic [6:0]             r_mode;

    logic [COUNT_WIDTH-1:0] n_count  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] n_cmp_a  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] n_cmp_b  [NUM_TIMERS];
    logic [2:0]             n_clk_sel  [NUM_TIMERS];
    logic [1:0]             n_edge_sel [NUM_TIMERS];
    logic [1:0]             n_clr_sel  [NUM_TIMERS];
    logic [2:0]             n_ier    [NUM_TIMERS];
    logic [2:0]             n_flags  [NUM_TIMERS];
    logic [2:0]             n_phase  [NUM_TIMERS];
    logic [4:0]             n_start;
    logic [4:0]             n_sync;
    logic [6:0]             n_mode;

    logic [7:0]       n_read_data;
    logic [SLOTS-1:0] n_pending;
    logic [1:0]       n_cause [SLOTS];

    // ------------------------------------------------------------------
    // Address decode
    // ------------------------------------------------------------------
    // Timers 0 to 2 sit in ten-byte windows from 0x04; timers 3 and 4 have
    // wider windows of their own. Anything else is a shared register or
    // unmapped. A window of an absent timer decodes as unmapped.
    logic [2:0] dec_timer;
    logic [5:0] dec_off;
    logic       dec_window;
    logic       dec_timer_hit;
    logic [3:0] dec_reg;
    logic       dec_shared;

    always_comb begin
        dec_timer  = 3'd0;
        dec_off    = 6'd0;
        dec_window = 1'b1;
        if (r_addr >= BASE_T4) begin
            dec_timer = 3'd4;
            dec_off   = r_addr - BASE_T4;
        end else if (r_addr >= BASE_T3 && r_addr < END_T3) begin
            dec_timer = 3'd3;
            dec_off   = r_addr - BASE_T3;
        end else if (r_addr >= BASE_T0 && r_addr < BASE_T3) begin
            if (r_addr < BASE_T0 + TIMER_STRIDE) begin
                dec_timer = 3'd0;
                dec_off   = r_addr - BASE_T0;
            end else if (r_addr < BASE_T0 + 6'(2 * TIMER_STRIDE)) begin
                dec_timer = 3'd1;
                dec_off   = r_addr - (BASE_T0 + TIMER_STRIDE);
            end else begin
                dec_timer = 3'd2;
                dec_off   = r_addr - (BASE_T0 + 6'(2 * TIMER_STRIDE));
            end
        end else begin
            dec_window = 1'b0;
        end
        dec_reg       = dec_off[3:0];
        dec_timer_hit = dec_window && (int'(dec_timer) < NUM_TIMERS);
        dec_shared    = (r_addr < ADDR_FIRST_TIMER);
    end

    // ------------------------------------------------------------------
    // Next state and result for the item in the input register
    // ------------------------------------------------------------------
    logic [15:0]            b16;
    logic [31:0]            wd_wide;
    logic [31:0]            cnt_wide;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [3:0]             span;
    logic [2:0]             last;
    logic [2:0]             act;
    logic                   sel_here;

    always_comb begin
        b16      = {8'd0, r_wdata[7:0]};
        wd_wide  = {16'd0, r_wdata};
        cnt_wide = '0;
        cnt_inc  = '0;
        span     = '0;
        last     = '0;
        act      = '0;
        sel_here = 1'b0;

        n_start     = r_start;
        n_sync      = r_sync;
        n_mode      = r_mode;
        n_read_data = '0;

        for (int i = 0; i < NUM_TIMERS; i++) begin
            n_count[i]    = r_count[i];
            n_cmp_a[i]    = r_cmp_a[i];
            n_cmp_b[i]    = r_cmp_b[i];
            n_clk_sel[i]  = r_clk_sel[i];
            n_edge_sel[i] = r_edge_sel[i];
            n_clr_sel[i]  = r_clr_sel[i];
            n_ier[i]      = r_ier[i];
            n_flags[i]    = r_flags[i];
            n_phase[i]    = r_phase[i];
        end

        case (t_op'(r_op))
            OP_TICK: begin
                // Every running timer with a prescaled clock select moves on.
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (r_start[i] && !r_clk_sel[i][2]) begin
                        span = 4'd1 << r_clk_sel[i][1:0];
                        last = 3'(span - 4'd1);
                        if (r_phase[i] < last) begin
                            n_phase[i] = r_phase[i] + 3'd1;
                        end else begin
                            n_phase[i] = 3'd0;
                            cnt_inc    = r_count[i] + COUNT_WIDTH'(1);
                            n_count[i] = cnt_inc;
                            if (cnt_inc == r_cmp_a[i]) begin
                                n_flags[i] = r_flags[i] | 3'b001;
                                if (r_clr_sel[i] == 2'd1) begin
                                    n_count[i] = '0;
                                end
                            end
                        end
                    end
                end
            end
            OP_READ_BYTE: begin
                if (dec_timer_hit) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (int'(dec_timer) == i && dec_reg == REG_FLAGS) begin
                            n_read_data = {5'd0, r_flags[i]} | FLAG_READ_PAD;
                        end
                    end
                end else if (dec_shared) begin
                    case (r_addr)
                        ADDR_START: n_read_data = {3'd0, r_start} | SHARED_READ_PAD;
                        ADDR_SYNC:  n_read_data = {3'd0, r_sync} | SHARED_READ_PAD;
                        ADDR_MODE:  n_read_data = {1'b0, r_mode};
                        default:    n_read_data = '0;
                    endcase
                end
            end
            OP_WRITE_BYTE: begin
                if (dec_timer_hit) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        sel_here = (int'(dec_timer) == i);
                        cnt_wide = '0;
                        cnt_wide[COUNT_WIDTH-1:0] = r_count[i];
                        if (sel_here) begin
                            case (dec_reg)
                                REG_CTRL: begin
                                    n_clk_sel[i]  = r_wdata[2:0];
                                    n_edge_sel[i] = r_wdata[4:3];
                                    n_clr_sel[i]  = r_wdata[6:5];
                                    n_phase[i]    = 3'd0;
                                end
                                REG_IER: begin
                                    n_ier[i] = r_wdata[2:0];
                                end
                                REG_FLAGS: begin
                                    // Flags are cleared by writing zero bits.
                                    n_flags[i] = r_flags[i] & r_wdata[2:0];
                                end
                                REG_CNT_HI: begin
                                    cnt_wide[15:8] = r_wdata[7:0];
                                    n_count[i]     = cnt_wide[COUNT_WIDTH-1:0];
                                    n_phase[i]     = 3'd0;
                                end
                                REG_CNT_LO: begin
                                    cnt_wide[7:0] = b16[7:0];
                                    n_count[i]    = cnt_wide[COUNT_WIDTH-1:0];
                                    n_phase[i]    = 3'd0;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end else if (dec_shared) begin
                    case (r_addr)
                        ADDR_START: begin
                            // A timer that is newly started begins a fresh
                            // prescaler period.
                            for (int i = 0; i < NUM_TIMERS; i++) begin
                                if (r_wdata[i] && !r_start[i]) begin
                                    n_phase[i] = 3'd0;
                                end
                            end
                            n_start = r_wdata[4:0];
                        end
                        ADDR_SYNC: n_sync = r_wdata[4:0];
                        ADDR_MODE: n_mode = r_wdata[6:0];
                        default: begin
                        end
                    endcase
                end
            end
            OP_WRITE_HALF: begin
                if (dec_timer_hit) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (int'(dec_timer) == i) begin
                            case (dec_reg)
                                REG_CNT_HI: begin
                                    n_count[i] = wd_wide[COUNT_WIDTH-1:0];
                                    n_phase[i] = 3'd0;
                                end
                                REG_CMP_A: begin
                                    n_cmp_a[i] = wd_wide[COUNT_WIDTH-1:0];
                                    n_phase[i] = 3'd0;
                                end
                                REG_CMP_B: begin
                                    n_cmp_b[i] = wd_wide[COUNT_WIDTH-1:0];
                                    n_phase[i] = 3'd0;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Interrupt state after the item: lowest set and enabled flag wins.
        n_pending = '0;
        for (int s = 0; s < SLOTS; s++) begin
            n_cause[s] = CAUSE_CMP_A;
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            act = n_ier[i] & n_flags[i];
            n_pending[i] = |act;
            if (act[0]) begin
                n_cause[i] = CAUSE_CMP_A;
            end else if (act[1]) begin
                n_cause[i] = CAUSE_FLAG1;
            end else if (act[2]) begin
                n_cause[i] = CAUSE_FLAG2;
            end else begin
                n_cause[i] = CAUSE_CMP_A;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_process) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
        end
        if (s1_process) begin
            r_read_data <= n_read_data;
            r_pending   <= n_pending;
            for (int s = 0; s < SLOTS; s++) begin
                r_cause[s] <= n_cause[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_sync  <= '0;
            r_mode  <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]    <= '0;
                r_cmp_a[i]    <= '0;
                r_cmp_b[i]    <= '0;
                r_clk_sel[i]  <= '0;
                r_edge_sel[i] <= '0;
                r_clr_sel[i]  <= '0;
                r_ier[i]      <= '0;
                r_flags[i]    <= '0;
                r_phase[i]    <= '0;
            end
        end else if (s1_process) begin
            r_start <= n_start;
            r_sync  <= n_sync;
            r_mode  <= n_mode;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]    <= n_count[i];
                r_cmp_a[i]    <= n_cmp_a[i];
                r_cmp_b[i]    <= n_cmp_b[i];
                r_clk_sel[i]  <= n_clk_sel[i];
                r_edge_sel[i] <= n_edge_sel[i];
                r_clr_sel[i]  <= n_clr_sel[i];
                r_ier[i]      <= n_ier[i];
                r_flags[i]    <= n_flags[i];
                r_phase[i]    <= n_phase[i];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_irq_pending  = r_pending;
    assign o_irq_cause_t0 = r_cause[0];
    assign o_irq_cause_t1 = r_cause[1];
    assign o_irq_cause_t2 = r_cause[2];
    assign o_irq_cause_t3 = r_cause[3];
    assign o_irq_cause_t4 = r_cause[4];

endmodule

// ===== hdl/fcct_checker.sv =====
// ----------------------------------------------------------------------------
// fcct_checker
// Port-level checks on the compare timer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcct_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [fcct_pkg::SLOTS-1:0]  o_irq_pending,
    input logic [1:0]                  o_irq_cause_t0,
    input logic [1:0]                  o_irq_cause_t1,
    input logic [1:0]                  o_irq_cause_t2,
    input logic [1:0]                  o_irq_cause_t3,
    input logic [1:0]                  o_irq_cause_t4
);
    import fcct_pkg::*;

    logic cause_idle_ok;
    logic cause_range_ok;

    assign cause_idle_ok  = (o_irq_pending[0] || o_irq_cause_t0 == CAUSE_CMP_A)
                         && (o_irq_pending[1] || o_irq_cause_t1 == CAUSE_CMP_A)
                         && (o_irq_pending[2] || o_irq_cause_t2 == CAUSE_CMP_A)
                         && (o_irq_pending[3] || o_irq_cause_t3 == CAUSE_CMP_A)
                         && (o_irq_pending[4] || o_irq_cause_t4 == CAUSE_CMP_A);

    assign cause_range_ok = o_irq_cause_t0 != CAUSE_INVALID
                         && o_irq_cause_t1 != CAUSE_INVALID
                         && o_irq_cause_t2 != CAUSE_INVALID
                         && o_irq_cause_t3 != CAUSE_INVALID
                         && o_irq_cause_t4 != CAUSE_INVALID;

    // A held result must stay offered until it is taken.
    `FCCT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "held result dropped")

    // The input side only backs up when the result register is full and held.
    `FCCT_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled early")

    // A timer without a pending interrupt reports the default cause.
    `FCCT_ASSERT_NOW(a_cause_idle, o_out_valid, cause_idle_ok, "cause without interrupt")

    // Only three flag bits exist, so the top cause code never appears.
    `FCCT_ASSERT_NOW(a_cause_range, o_out_valid, cause_range_ok, "cause code out of range")

endmodule

bind five_channel_compare_timer fcct_checker u_fcct_checker (.*);

// ===== tb/sv/five_channel_compare_timer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_channel_compare_timer_test
// Self-checking bench for the five-channel compare timer. A short table of
// directed items covers reset values, the read pads, ignored writes and a
// first compare match. Random traffic follows, built mostly from complete
// set-up-and-count sequences. It runs under several idling mixes and one
// long receiver hold-off. Every result item is checked against its typed
// table result or a cycle-free model of the timer state kept in the bench.
// ----------------------------------------------------------------------------
module five_channel_compare_timer_test;

    import fcct_pkg::*;

    localparam int NUM_TIMERS   = 5;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_PRINTS   = 40;

    // Clock select values above this one stop the counter.
    localparam logic [2:0] CKS_SLOWEST   = 3'd3;
    // Clear select value that zeroes the counter on a compare match.
    localparam logic [1:0] CCLR_ON_MATCH = 2'd1;

    // One result item as the block presents it.
    typedef struct packed {
        logic [7:0]            read_data;
        logic [SLOTS-1:0]      irq_pending;
        logic [SLOTS-1:0][1:0] irq_cause;
    } t_timer_result;

    // One row of the directed table. Where typed is set, the result is
    // written into the row; otherwise the model supplies it.
    typedef struct {
        t_op           op;
        logic [5:0]    addr;
        logic [15:0]   wdata;
        bit            typed;
        t_timer_result result;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [5:0]  i_addr;
    logic [15:0] i_wdata;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_read_data;
    logic [SLOTS-1:0] o_irq_pending;
    logic [1:0]  o_irq_cause_t0;
    logic [1:0]  o_irq_cause_t1;
    logic [1:0]  o_irq_cause_t2;
    logic [1:0]  o_irq_cause_t3;
    logic [1:0]  o_irq_cause_t4;

    five_channel_compare_timer #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (16)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_addr         (i_addr),
        .i_wdata        (i_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_irq_pending  (o_irq_pending),
        .o_irq_cause_t0 (o_irq_cause_t0),
        .o_irq_cause_t1 (o_irq_cause_t1),
        .o_irq_cause_t2 (o_irq_cause_t2),
        .o_irq_cause_t3 (o_irq_cause_t3),
        .o_irq_cause_t4 (o_irq_cause_t4)
    );

    // Model copy of the timer state, updated once per accepted item.
    logic [15:0] tmr_count     [SLOTS];
    logic [15:0] tmr_compare_a [SLOTS];
    logic [15:0] tmr_compare_b [SLOTS];
    logic [2:0]  tmr_clk_sel   [SLOTS];
    logic [1:0]  tmr_edge_sel  [SLOTS];
    logic [1:0]  tmr_clr_sel   [SLOTS];
    logic [2:0]  tmr_irq_en    [SLOTS];
    logic [2:0]  tmr_flags     [SLOTS];
    logic [2:0]  tmr_phase     [SLOTS];
    logic [4:0]  start_reg;
    logic [4:0]  sync_reg;
    logic [6:0]  mode_reg;

    // Results still owed by the block, oldest first.
    t_timer_result expected_timer_results [$];
    t_stim_row     directed_rows [$];

    int unsigned mismatch_count;
    int unsigned result_index;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_request;
    bit          hold_done;

    // The clock: 10 ns period, starting low.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // A hard ceiling on the run, far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Window base address of one timer. Timers 0 to 2 are evenly spaced;
    // timers 3 and 4 sit at their own bases.
    function automatic logic [5:0] timer_base(input int t);
        case (t)
            3: return BASE_T3;
            4: return BASE_T4;
            default: return BASE_T0 + 6'(t) * TIMER_STRIDE;
        endcase
    endfunction

    // Applies one item to the model state and returns the result the block
    // must produce for it. Ticks advance every running timer through its
    // prescaler; bus items decode the address into a timer window or the
    // shared registers, with everything else ignored.
    function automatic t_timer_result predict_timer_step(input t_op op,
                                                         input logic [5:0] addr,
                                                         input logic [15:0] wdata);
        t_timer_result res;
        int            sel;
        int unsigned   offs;
        int unsigned   last_phase;
        logic [7:0]    byte_in;
        logic [2:0]    active;
        res     = '0;
        byte_in = wdata[7:0];
        sel     = -1;
        offs    = 32'(addr);
        if (addr >= BASE_T4) begin
            sel  = 4;
            offs = 32'(addr - BASE_T4);
        end else if (addr >= BASE_T3 && addr < END_T3) begin
            sel  = 3;
            offs = 32'(addr - BASE_T3);
        end else if (addr >= BASE_T0 && addr < BASE_T3) begin
            sel  = int'((addr - BASE_T0) / TIMER_STRIDE);
            offs = 32'((addr - BASE_T0) % TIMER_STRIDE);
        end
        // Windows of timers that are not built decode as nothing at all.
        if (sel >= NUM_TIMERS) begin
            sel  = -1;
            offs = 'hFF;
        end

        case (op)
            OP_TICK: begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (start_reg[t] && tmr_clk_sel[t] <= CKS_SLOWEST) begin
                        last_phase = (1 << tmr_clk_sel[t]) - 1;
                        if (tmr_phase[t] < last_phase) begin
                            tmr_phase[t] = tmr_phase[t] + 3'd1;
                        end else begin
                            tmr_phase[t] = '0;
                            tmr_count[t] = tmr_count[t] + 16'd1;
                            if (tmr_count[t] == tmr_compare_a[t]) begin
                                tmr_flags[t][0] = 1'b1;
                                if (tmr_clr_sel[t] == CCLR_ON_MATCH) begin
                                    tmr_count[t] = '0;
                                end
                            end
                        end
                    end
                end
            end
            OP_READ_BYTE: begin
                if (sel >= 0) begin
                    if (offs == REG_FLAGS) begin
                        res.read_data = {5'b0, tmr_flags[sel]} | FLAG_READ_PAD;
                    end
                end else if (offs == ADDR_START) begin
                    res.read_data = {3'b0, start_reg} | SHARED_READ_PAD;
                end else if (offs == ADDR_SYNC) begin
                    res.read_data = {3'b0, sync_reg} | SHARED_READ_PAD;
                end else if (offs == ADDR_MODE) begin
                    res.read_data = {1'b0, mode_reg};
                end
            end
            OP_WRITE_BYTE: begin
                if (sel >= 0) begin
                    case (offs)
                        REG_CTRL: begin
                            tmr_clk_sel[sel]  = byte_in[2:0];
                            tmr_edge_sel[sel] = byte_in[4:3];
                            tmr_clr_sel[sel]  = byte_in[6:5];
                            tmr_phase[sel]    = '0;
                        end
                        REG_IER: begin
                            tmr_irq_en[sel] = byte_in[2:0];
                        end
                        REG_FLAGS: begin
                            tmr_flags[sel] = tmr_flags[sel] & byte_in[2:0];
                        end
                        REG_CNT_HI: begin
                            tmr_count[sel][15:8] = byte_in;
                            tmr_phase[sel]       = '0;
                        end
                        REG_CNT_LO: begin
                            tmr_count[sel][7:0] = byte_in;
                            tmr_phase[sel]      = '0;
                        end
                        default: begin
                        end
                    endcase
                end else if (offs == ADDR_START) begin
                    // Only a timer that is being started has its phase restarted.
                    for (int t = 0; t < NUM_TIMERS; t++) begin
                        if (byte_in[t] && !start_reg[t]) begin
                            tmr_phase[t] = '0;
                        end
                    end
                    start_reg = byte_in[4:0];
                end else if (offs == ADDR_SYNC) begin
                    sync_reg = byte_in[4:0];
                end else if (offs == ADDR_MODE) begin
                    mode_reg = byte_in[6:0];
                end
            end
            OP_WRITE_HALF: begin
                if (sel >= 0) begin
                    if (offs == REG_CNT_HI) begin
                        tmr_count[sel] = wdata;
                        tmr_phase[sel] = '0;
                    end else if (offs == REG_CMP_A) begin
                        tmr_compare_a[sel] = wdata;
                        tmr_phase[sel]     = '0;
                    end else if (offs == REG_CMP_B) begin
                        tmr_compare_b[sel] = wdata;
                        tmr_phase[sel]     = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        // Interrupt state after the item: the lowest enabled and set flag.
        for (int t = 0; t < NUM_TIMERS; t++) begin
            active = tmr_irq_en[t] & tmr_flags[t];
            if (active != '0) begin
                res.irq_pending[t] = 1'b1;
                if (active[0]) begin
                    res.irq_cause[t] = CAUSE_CMP_A;
                end else if (active[1]) begin
                    res.irq_cause[t] = CAUSE_FLAG1;
                end else begin
                    res.irq_cause[t] = CAUSE_FLAG2;
                end
            end
        end
        return res;
    endfunction

    // Offers one item, idling first as the current mix asks, and holds it
    // until the block takes it. The model is stepped at the accepting edge.
    task automatic offer_item(input t_op op, input logic [5:0] addr,
                              input logic [15:0] wdata, input bit typed,
                              input t_timer_result typed_result);
        t_timer_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_addr      <= addr;
        i_wdata     <= wdata;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predicted = predict_timer_step(op, addr, wdata);
        expected_timer_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic add_row(input t_op op, input logic [5:0] addr,
                           input logic [15:0] wdata, input bit typed,
                           input logic [7:0] read_data);
        t_stim_row row;
        row.op     = op;
        row.addr   = addr;
        row.wdata  = wdata;
        row.typed  = typed;
        row.result = '0;
        row.result.read_data = read_data;
        directed_rows.push_back(row);
    endtask

    // Random traffic. Most of it is a complete sequence on one timer:
    // compare value, control, interrupt enable, counter, start, a run of
    // ticks, a flag read and a flag write. The counter sometimes starts just
    // below the top so that it wraps. The rest is single items with random
    // content, a quarter of them at any address in the map.
    task automatic run_random(input int n_items);
        int          sent;
        int          t;
        int          n_ticks;
        int unsigned pick;
        logic [5:0]  base;
        logic [5:0]  addr;
        logic [15:0] data;
        logic [7:0]  ctrl;
        t_op         op;
        sent = 0;
        while (sent < n_items) begin
            t    = $urandom_range(0, NUM_TIMERS - 1);
            base = timer_base(t);
            if ($urandom_range(0, 99) < 40) begin
                data = 16'($urandom_range(0, 12));
                offer_item(OP_WRITE_HALF, base + REG_CMP_A, data, 0, '0);
                ctrl      = 8'($urandom_range(0, 255));
                ctrl[2:0] = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, 7));
                if ($urandom_range(0, 1)) begin
                    ctrl[6:5] = CCLR_ON_MATCH;
                end
                data = {8'($urandom_range(0, 255)), ctrl};
                offer_item(OP_WRITE_BYTE, base + REG_CTRL, data, 0, '0);
                offer_item(OP_WRITE_BYTE, base + REG_IER, 16'($urandom), 0, '0);
                data = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 4))
                                                   : '0;
                offer_item(OP_WRITE_HALF, base + REG_CNT_HI, data, 0, '0);
                data = 16'($urandom);
                data[t] = 1'b1;
                offer_item(OP_WRITE_BYTE, ADDR_START, data, 0, '0);
                n_ticks = $urandom_range(2, 30);
                repeat (n_ticks) begin
                    offer_item(OP_TICK, 6'($urandom_range(0, 63)), 16'($urandom), 0, '0);
                end
                offer_item(OP_READ_BYTE, base + REG_FLAGS, 16'($urandom), 0, '0);
                offer_item(OP_WRITE_BYTE, base + REG_FLAGS, 16'($urandom), 0, '0);
                sent += 7 + n_ticks;
            end else begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0) begin
                    addr = 6'($urandom_range(0, 63));
                end else begin
                    addr = base + 6'($urandom_range(0, 9));
                end
                data = 16'($urandom);
                if (pick < 40) begin
                    op = OP_TICK;
                end else if (pick < 60) begin
                    op = OP_READ_BYTE;
                end else if (pick < 85) begin
                    op = OP_WRITE_BYTE;
                end else begin
                    op = OP_WRITE_HALF;
                end
                offer_item(op, addr, data, 0, '0);
                sent++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                     result_index, what, got, want);
        end
    endtask

    // Receiver. It stalls at random at the current rate, except when a
    // hold-off is requested: then it stalls for a long count of cycles so
    // that both internal registers fill and the block stalls its input.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Result checker. Values are sampled at the edge, so they are the ones
    // that were presented during the cycle before it.
    always @(posedge i_clk) begin : result_check
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.read_data   = o_read_data;
            got.irq_pending = o_irq_pending;
            got.irq_cause   = {o_irq_cause_t4, o_irq_cause_t3, o_irq_cause_t2,
                               o_irq_cause_t1, o_irq_cause_t0};
            if (expected_timer_results.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(got), 0);
            end else begin
                want = expected_timer_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
                end
                if (got.irq_pending !== want.irq_pending) begin
                    report_mismatch("irq_pending", 32'(got.irq_pending),
                                    32'(want.irq_pending));
                end
                for (int t = 0; t < SLOTS; t++) begin
                    if (got.irq_cause[t] !== want.irq_cause[t]) begin
                        report_mismatch($sformatf("irq_cause_t%0d", t),
                                        32'(got.irq_cause[t]), 32'(want.irq_cause[t]));
                    end
                end
            end
            result_index++;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_TICK;
        i_addr      <= '0;
        i_wdata     <= '0;
        mismatch_count = 0;
        result_index   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;

        // The model starts from the reset state: everything zero.
        for (int t = 0; t < SLOTS; t++) begin
            tmr_count[t]     = '0;
            tmr_compare_a[t] = '0;
            tmr_compare_b[t] = '0;
            tmr_clk_sel[t]   = '0;
            tmr_edge_sel[t]  = '0;
            tmr_clr_sel[t]   = '0;
            tmr_irq_en[t]    = '0;
            tmr_flags[t]     = '0;
            tmr_phase[t]     = '0;
        end
        start_reg = '0;
        sync_reg  = '0;
        mode_reg  = '0;

        // Directed table. The first rows read the reset values and pads, the gaps in
        // the map, shared registers written full, and the ignored halfword write to
        // a shared register. The later rows set timer 0 up to match at 2 and clear,
        // and timer 4 to wrap from the top onto a compare value of 0.
        add_row(OP_READ_BYTE,  ADDR_START,            '0,       1, SHARED_READ_PAD);
        add_row(OP_READ_BYTE,  ADDR_SYNC,             '0,       1, SHARED_READ_PAD);
        add_row(OP_READ_BYTE,  ADDR_MODE,             '0,       1, 8'h00);
        add_row(OP_READ_BYTE,  BASE_T4 + REG_FLAGS,   '0,       1, FLAG_READ_PAD);
        add_row(OP_READ_BYTE,  ADDR_MODE + 6'd1,      '0,       1, 8'h00);
        add_row(OP_READ_BYTE,  END_T3,                '0,       1, 8'h00);
        add_row(OP_READ_BYTE,  '1,                    '0,       1, 8'h00);
        add_row(OP_WRITE_BYTE, ADDR_SYNC,             16'hFFFF, 1, 8'h00);
        add_row(OP_READ_BYTE,  ADDR_SYNC,             '0,       1, 8'h7F);
        add_row(OP_WRITE_BYTE, ADDR_MODE,             16'hFFFF, 1, 8'h00);
        add_row(OP_READ_BYTE,  ADDR_MODE,             '0,       1, 8'h7F);
        add_row(OP_WRITE_HALF, ADDR_START,            16'hFFFF, 1, 8'h00);
        add_row(OP_READ_BYTE,  ADDR_START,            '0,       1, SHARED_READ_PAD);
        add_row(OP_WRITE_HALF, BASE_T0 + REG_CMP_A,   16'h0002, 0, 8'h00);
        add_row(OP_WRITE_BYTE, BASE_T0 + REG_CTRL,    16'h0020, 0, 8'h00);
        add_row(OP_WRITE_BYTE, BASE_T0 + REG_IER,     16'h0007, 0, 8'h00);
        add_row(OP_WRITE_HALF, BASE_T4 + REG_CNT_HI,  16'hFFFF, 0, 8'h00);
        add_row(OP_WRITE_BYTE, BASE_T4 + REG_IER,     16'h0001, 0, 8'h00);
        add_row(OP_WRITE_BYTE, timer_base(2) + REG_CNT_HI, 16'h00AB, 0, 8'h00);
        add_row(OP_WRITE_BYTE, timer_base(2) + REG_CNT_LO, 16'h00CD, 0, 8'h00);
        add_row(OP_WRITE_HALF, timer_base(2) + REG_CMP_B,  16'hFFFF, 0, 8'h00);
        add_row(OP_WRITE_BYTE, ADDR_START,            16'h00FF, 0, 8'h00);
        add_row(OP_TICK,       '0,                    '0,       0, 8'h00);
        add_row(OP_TICK,       '0,                    '0,       0, 8'h00);
        add_row(OP_READ_BYTE,  BASE_T0 + REG_FLAGS,   '0,       0, 8'h00);
        add_row(OP_WRITE_BYTE, BASE_T0 + REG_FLAGS,   16'h00FE, 0, 8'h00);

        // Synchronous reset, released before the first item is offered.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                       directed_rows[i].typed, directed_rows[i].result);
        end

        // Random traffic under each idling mix in turn, starting with none.
        run_random(90);
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        run_random(90);
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        run_random(90);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_random(90);

        // Long hold-off at the receiver while items keep coming, so that the
        // block backs up and stalls its input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        run_random(60);
        i_in_valid <= 1'b0;

        // Let the block drain, then idle on for anything stray.
        while (expected_timer_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
